FILE: src/assert_macros.svh
// Assertion macros of the checker module of the frame manager.
// No dependencies; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define CBFM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define CBFM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/cbfm_pkg.sv
// Shared types and constants of the clock buffer frame manager.
// No dependencies; used by scoped names in the top level, the sequencer and the checker.
package cbfm_pkg;

   localparam int FRAMES_DEF = 8;
   localparam int PAGE_BITS  = 16;
   localparam int FIELD_BITS = 3;
   localparam int PIN_BITS   = 8;
   localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

   typedef enum logic [1:0] {
      ACT_LOOKUP = 2'd0,
      ACT_PIN    = 2'd1,
      ACT_UNPIN  = 2'd2,
      ACT_DIRTY  = 2'd3
   } action_type;

   typedef struct packed {
      action_type              action;
      logic [PAGE_BITS-1:0]    page_id;
      logic [FIELD_BITS-1:0]   frame_sel;
   } req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0]   frame;
      logic                    hit;
      logic                    writeback;
      logic [PAGE_BITS-1:0]    writeback_page;
      logic [PAGE_BITS-1:0]    assigned_page;
      logic                    forced;
   } rsp_type;

   typedef struct packed {
      logic [PIN_BITS-1:0]     pins;
      logic                    referenced;
      logic                    dirty;
   } meta_type;

endpackage

FILE: src/clock_buffer_frame_manager.sv
// Top level of the clock buffer frame manager: sequencer, two memories, result register.
// Depends on cbfm_pkg, cbfm_ram and cbfm_seq.
//
// Usage: an item on the req_ channel asks for a lookup, a pin, an unpin or a
// mark-dirty action; each item yields exactly one item on the rsp_ channel.
// Both channels use valid and ready; one item is worked on at a time.
// Page ids sit in one memory and pin count, reference and dirty flags in a
// second; both have one read and one write port, one frame per cycle.
// A lookup searches the frames in order from frame 0; a miss then sweeps the
// clock hand, which visits at most 2 * FRAMES + 1 frames, and a pin of a fresh
// page skips the search. The sweep of the clock hand over the metadata memory
// sets the worst case.
// The next item is taken in the cycle in which the result of its predecessor
// first shows.
// Reset empties all frames, parks the hand at frame 0 and restarts the page
// counter at 0; no clearing pass is needed. A result waits in an output
// register while rsp_ready is low; the next item is taken meanwhile and its
// result is held until the register frees.
module clock_buffer_frame_manager #(
   parameter int FRAMES = cbfm_pkg::FRAMES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cbfm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cbfm_pkg::rsp_type rsp_data
);

   localparam int IDX_BITS = $clog2(FRAMES);

   logic                           done_valid;
   logic                           done_take;
   cbfm_pkg::rsp_type              done_data;
   logic [IDX_BITS-1:0]            ram_raddr;
   logic [IDX_BITS-1:0]            ram_waddr;
   logic                           page_we;
   logic [cbfm_pkg::PAGE_BITS-1:0] page_wdata;
   logic [cbfm_pkg::PAGE_BITS-1:0] page_rdata;
   logic                           meta_we;
   cbfm_pkg::meta_type             meta_wdata;
   cbfm_pkg::meta_type             meta_rdata;

   logic                           rsp_valid_ff, rsp_valid_in;
   cbfm_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   cbfm_seq #(
      .FRAMES (FRAMES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .done_valid (done_valid),
      .done_take  (done_take),
      .done_data  (done_data),
      .ram_raddr  (ram_raddr),
      .ram_waddr  (ram_waddr),
      .page_we    (page_we),
      .page_wdata (page_wdata),
      .page_rdata (page_rdata),
      .meta_we    (meta_we),
      .meta_wdata (meta_wdata),
      .meta_rdata (meta_rdata)
   );

   cbfm_ram #(
      .DEPTH (FRAMES),
      .WIDTH (cbfm_pkg::PAGE_BITS)
   ) u_page_ram (
      .clock (clock),
      .we    (page_we),
      .waddr (ram_waddr),
      .wdata (page_wdata),
      .raddr (ram_raddr),
      .rdata (page_rdata)
   );

   cbfm_ram #(
      .DEPTH (FRAMES),
      .WIDTH ($bits(cbfm_pkg::meta_type))
   ) u_meta_ram (
      .clock (clock),
      .we    (meta_we),
      .waddr (ram_waddr),
      .wdata (meta_wdata),
      .raddr (ram_raddr),
      .rdata (meta_rdata)
   );

   assign done_take = done_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (done_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: src/cbfm_ram.sv
// Synchronous single-port-write, single-port-read memory with registered read data.
// No dependencies; holds page ids and per-frame metadata of the frame manager.
module cbfm_ram #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/cbfm_seq.sv
// Sequencer of the frame manager: page search, clock sweep and frame updates.
// Depends on cbfm_pkg; drives the page and metadata memories held in cbfm_ram.
module cbfm_seq #(
   parameter int FRAMES = cbfm_pkg::FRAMES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cbfm_pkg::req_type                   req_data,
   output logic                                done_valid,
   input  logic                                done_take,
   output cbfm_pkg::rsp_type                   done_data,
   output logic [$clog2(FRAMES)-1:0]           ram_raddr,
   output logic [$clog2(FRAMES)-1:0]           ram_waddr,
   output logic                                page_we,
   output logic [cbfm_pkg::PAGE_BITS-1:0]      page_wdata,
   input  logic [cbfm_pkg::PAGE_BITS-1:0]      page_rdata,
   output logic                                meta_we,
   output cbfm_pkg::meta_type                  meta_wdata,
   input  cbfm_pkg::meta_type                  meta_rdata
);

   localparam int IDX_BITS  = $clog2(FRAMES);
   localparam int STEP_BITS = $clog2(2 * FRAMES + 1);
   localparam logic [IDX_BITS-1:0]  LAST_IDX  = IDX_BITS'(FRAMES - 1);
   localparam logic [STEP_BITS-1:0] SWEEP_END = STEP_BITS'(2 * FRAMES);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SEARCH = 5'b00010,
      ST_SWEEP  = 5'b00100,
      ST_ACCESS = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type                      state_ff, state_in;
   cbfm_pkg::req_type              item_ff, item_in;
   logic [IDX_BITS-1:0]            ptr_ff, ptr_in;
   logic [STEP_BITS-1:0]           step_ff, step_in;
   logic [IDX_BITS-1:0]            hand_ff, hand_in;
   logic [cbfm_pkg::PAGE_BITS-1:0] next_page_ff, next_page_in;
   logic [cbfm_pkg::PAGE_BITS-1:0] load_page_ff, load_page_in;
   logic [FRAMES-1:0]              valid_ff, valid_in;
   cbfm_pkg::rsp_type              res_ff, res_in;

   cbfm_pkg::meta_type             cur_meta;
   logic [IDX_BITS-1:0]            next_ptr;
   logic                           is_pin;
   logic                           page_match;
   logic                           forced_now;
   logic                           take_now;
   logic                           wb_now;

   // Frames that were never loaded read as all-zero metadata.
   assign cur_meta   = valid_ff[ptr_ff] ? meta_rdata : '0;
   assign next_ptr   = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
   assign is_pin     = (item_ff.action == cbfm_pkg::ACT_PIN);
   assign page_match = valid_ff[ptr_ff] && (page_rdata == item_ff.page_id);
   assign forced_now = (step_ff == SWEEP_END);
   assign take_now   = forced_now || ((cur_meta.pins == '0) && !cur_meta.referenced);
   assign wb_now     = valid_ff[ptr_ff] && cur_meta.dirty;

   assign req_ready  = (state_ff == ST_IDLE);
   assign done_valid = (state_ff == ST_DONE);
   assign done_data  = res_ff;
   assign ram_waddr  = ptr_ff;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      ptr_in       = ptr_ff;
      step_in      = step_ff;
      hand_in      = hand_ff;
      next_page_in = next_page_ff;
      load_page_in = load_page_ff;
      valid_in     = valid_ff;
      res_in       = res_ff;
      ram_raddr    = '0;
      page_we      = 1'b0;
      page_wdata   = load_page_ff;
      meta_we      = 1'b0;
      meta_wdata   = cur_meta;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               unique case (req_data.action)
                  cbfm_pkg::ACT_LOOKUP, cbfm_pkg::ACT_PIN: begin
                     if ((req_data.action == cbfm_pkg::ACT_PIN)
                         && (req_data.page_id >= next_page_ff)) begin
                        load_page_in = next_page_ff;
                        next_page_in = next_page_ff + 1'b1;
                        ram_raddr    = hand_ff;
                        ptr_in       = hand_ff;
                        step_in      = '0;
                        state_in     = ST_SWEEP;
                     end else begin
                        load_page_in = req_data.page_id;
                        ram_raddr    = '0;
                        ptr_in       = '0;
                        state_in     = ST_SEARCH;
                     end
                  end
                  cbfm_pkg::ACT_UNPIN, cbfm_pkg::ACT_DIRTY: begin
                     if (32'(req_data.frame_sel) >= FRAMES) begin
                        res_in       = '0;
                        res_in.frame = req_data.frame_sel;
                        state_in     = ST_DONE;
                     end else begin
                        ram_raddr = req_data.frame_sel[IDX_BITS-1:0];
                        ptr_in    = req_data.frame_sel[IDX_BITS-1:0];
                        state_in  = ST_ACCESS;
                     end
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (page_match) begin
               meta_we               = 1'b1;
               meta_wdata.referenced = 1'b1;
               if (is_pin && (cur_meta.pins != cbfm_pkg::PIN_MAX)) begin
                  meta_wdata.pins = cur_meta.pins + 1'b1;
               end
               res_in               = '0;
               res_in.frame         = cbfm_pkg::FIELD_BITS'(ptr_ff);
               res_in.hit           = 1'b1;
               res_in.assigned_page = item_ff.page_id;
               state_in             = ST_DONE;
            end else if (ptr_ff == LAST_IDX) begin
               ram_raddr = hand_ff;
               ptr_in    = hand_ff;
               step_in   = '0;
               state_in  = ST_SWEEP;
            end else begin
               ram_raddr = ptr_ff + 1'b1;
               ptr_in    = ptr_ff + 1'b1;
            end
         end
         ST_SWEEP: begin
            if (take_now) begin
               page_we                = 1'b1;
               meta_we                = 1'b1;
               meta_wdata.pins        = is_pin ? cbfm_pkg::PIN_BITS'(1) : '0;
               meta_wdata.referenced  = 1'b1;
               meta_wdata.dirty       = 1'b0;
               valid_in[ptr_ff]       = 1'b1;
               hand_in                = ptr_ff;
               res_in                 = '0;
               res_in.frame           = cbfm_pkg::FIELD_BITS'(ptr_ff);
               res_in.writeback       = wb_now;
               res_in.writeback_page  = wb_now ? page_rdata : '0;
               res_in.assigned_page   = load_page_ff;
               res_in.forced          = forced_now;
               state_in               = ST_DONE;
            end else begin
               if (cur_meta.pins == '0) begin
                  meta_we               = 1'b1;
                  meta_wdata.referenced = 1'b0;
               end
               ram_raddr = next_ptr;
               ptr_in    = next_ptr;
               step_in   = step_ff + 1'b1;
            end
         end
         ST_ACCESS: begin
            meta_we = 1'b1;
            if (item_ff.action == cbfm_pkg::ACT_UNPIN) begin
               if (cur_meta.pins != '0) begin
                  meta_wdata.pins = cur_meta.pins - 1'b1;
               end
            end else if (valid_ff[ptr_ff]) begin
               meta_wdata.dirty = 1'b1;
            end
            res_in               = '0;
            res_in.frame         = item_ff.frame_sel;
            res_in.assigned_page = valid_ff[ptr_ff] ? page_rdata : '0;
            state_in             = ST_DONE;
         end
         ST_DONE: begin
            if (done_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hand_ff      <= '0;
         next_page_ff <= '0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         hand_ff      <= hand_in;
         next_page_ff <= next_page_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      ptr_ff       <= ptr_in;
      step_ff      <= step_in;
      load_page_ff <= load_page_in;
      res_ff       <= res_in;
   end

endmodule

FILE: src/cbfm_checker.sv
// Port-level checker of the clock buffer frame manager, bound to the top level.
// Depends on cbfm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cbfm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input cbfm_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input cbfm_pkg::rsp_type rsp_data
);

   `CBFM_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "result item after reset")
   `CBFM_ASSERT(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready, "second item taken while busy")
   `CBFM_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)), "stalled result item changed")
   `CBFM_ASSERT(a_wb_page_zero, clock, reset, (rsp_valid && !rsp_data.writeback) |-> (rsp_data.writeback_page == '0), "write-back page without write-back")
   `CBFM_ASSERT(a_hit_no_evict, clock, reset, (rsp_valid && rsp_data.hit) |-> (!rsp_data.writeback && !rsp_data.forced), "hit item reports an eviction")

endmodule

bind clock_buffer_frame_manager cbfm_checker u_cbfm_checker (.*);
